// File: design/rxsfw_pkg.sv
// Shared types, codes and constants of the serial frame writer.
`timescale 1ns / 1ps
package rxsfw_pkg;

  localparam int ADDRESS_BITS_DEFAULT = 4;
  localparam int DATA_BITS_DEFAULT    = 20;

  localparam int OP_BITS        = 3;
  localparam int FREQ_BITS      = 14;
  localparam int WORD_BITS      = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int US_BITS        = 8;
  localparam int TICK_BITS      = 16;

  localparam logic [OP_BITS-1:0] OP_SET_FREQ   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_POWER_UP   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POWER_DOWN = 3'd2;
  localparam logic [OP_BITS-1:0] OP_WAKE       = 3'd3;
  localparam logic [OP_BITS-1:0] OP_RAW_WRITE  = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TICKS_PER_US = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETUP_US     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_HIGH   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_US      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_GAP    = 3'd4;

  localparam logic [FREQ_BITS-1:0] FREQ_FLOOR      = 14'd479;
  localparam logic [WORD_BITS-1:0] POWER_UP_WORD   = 20'b11010000110111110011;
  localparam logic [WORD_BITS-1:0] POWER_DOWN_WORD = 20'b11111111111111111111;
  localparam logic [7:0]           REG_STATE       = 8'h0F;
  localparam logic [7:0]           REG_SYNTH_B     = 8'h01;
  localparam logic [7:0]           REG_POWER       = 8'h0A;

  typedef struct packed {
    logic               start;
    logic [US_BITS-1:0] us;
  } tmr_ctrl_t;

  typedef struct packed {
    logic load;
    logic advance;
  } shf_ctrl_t;

  typedef struct packed {
    logic lsb;
    logic last_bit;
    logic at_start;
  } shf_status_t;

endpackage

// File: design/rxsfw_timer.sv
// Microsecond prescaler and phase countdown that times the serial line.
`timescale 1ns / 1ps
module rxsfw_timer
  import rxsfw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [TICK_BITS-1:0] ticks_per_us,
  input  tmr_ctrl_t            ctrl,
  output logic                 done
);

  logic                 busy;
  logic [TICK_BITS-1:0] microsecond_prescale;
  logic [US_BITS-1:0]   phase_timer;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                 <= 1'b0;
      done                 <= 1'b0;
      microsecond_prescale <= '0;
      phase_timer          <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy                 <= 1'b1;
        microsecond_prescale <= '0;
        phase_timer          <= ctrl.us;
      end else if (busy) begin
        if (microsecond_prescale == ticks_per_us - TICK_BITS'(1)) begin
          microsecond_prescale <= '0;
          if (phase_timer == US_BITS'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            phase_timer <= phase_timer - US_BITS'(1);
          end
        end else begin
          microsecond_prescale <= microsecond_prescale + TICK_BITS'(1);
        end
      end
    end
  end

endmodule

// File: design/rxsfw_shifter.sv
// Frame shift register and bit counter, one bit out per advance.
`timescale 1ns / 1ps
module rxsfw_shifter
  import rxsfw_pkg::*;
#(
  parameter int FRAME_BITS = ADDRESS_BITS_DEFAULT + 1 + DATA_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  shf_ctrl_t             ctrl,
  input  logic [FRAME_BITS-1:0] load_frame,
  output shf_status_t           status
);

  localparam int IDX_BITS = $clog2(FRAME_BITS);

  logic [FRAME_BITS-1:0] frame_shift;
  logic [IDX_BITS-1:0]   bit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bit_index   <= '0;
    end else if (ctrl.load) begin
      frame_shift <= load_frame;
      bit_index   <= '0;
    end else if (ctrl.advance) begin
      frame_shift <= frame_shift >> 1;
      // wrap to zero after the final bit so the sequencer sees the frame end
      if (status.last_bit) begin
        bit_index <= '0;
      end else begin
        bit_index <= bit_index + IDX_BITS'(1);
      end
    end
  end

  assign status.lsb      = frame_shift[0];
  assign status.last_bit = (bit_index == IDX_BITS'(FRAME_BITS - 1));
  assign status.at_start = (bit_index == '0);

endmodule

// File: design/rx_synth_serial_frame_writer.sv
// Top level of the receiver synthesizer serial frame writer.
// Each accepted command becomes one register-write frame (two for wake: state
// register cleared, then power up) of ADDRESS_BITS address bits, a write bit
// of 1 and DATA_BITS data bits, sent least significant bit first; every bit is
// one output transfer, and frame_end marks the last bit of each frame. A frame
// opens with frame_gap_us of idle time; each bit then takes setup_time_us
// before its transfer is offered and clock_high_us plus hold_time_us after it
// is taken, each microsecond being counted out by the prescaler against
// ticks_per_microsecond. At reset values a 25-bit frame is about 230 us; the
// phase timer sets this figure, and any time that out_ready stays low adds to
// it. One command is handled at a time: in_ready is high only while no frame
// is being sent. Unused op codes are taken and produce no bits. Configuration
// writes are always taken.
`timescale 1ns / 1ps
module rx_synth_serial_frame_writer
  import rxsfw_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
  parameter int DATA_BITS    = DATA_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_BITS-1:0]        op,
  input  logic [FREQ_BITS-1:0]      frequency_mhz,
  input  logic [ADDRESS_BITS-1:0]   raw_address,
  input  logic [DATA_BITS-1:0]      raw_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      serial_bit,
  output logic                      frame_end,
  output logic                      last,
  output logic                      powered_down,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FRAME_BITS = ADDRESS_BITS + 1 + DATA_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_SETUP,
    S_SEND,
    S_HIGH,
    S_HOLD
  } state_t;

  state_t state, state_next;

  logic [TICK_BITS-1:0] ticks_per_microsecond;
  logic [US_BITS-1:0]   setup_time_us;
  logic [US_BITS-1:0]   clock_high_us;
  logic [US_BITS-1:0]   hold_time_us;
  logic [US_BITS-1:0]   frame_gap_us;

  logic second_frame_pending;
  logic power_down_flag;
  logic load_second;
  logic op_known;

  tmr_ctrl_t   tmr_ctrl;
  logic        tmr_done;
  shf_ctrl_t   shf_ctrl;
  shf_status_t shf_status;

  logic [FREQ_BITS-1:0]    freq_offset;
  logic [WORD_BITS-1:0]    freq_word;
  logic [ADDRESS_BITS-1:0] cmd_address;
  logic [DATA_BITS-1:0]    cmd_data;
  logic [FRAME_BITS-1:0]   cmd_frame;
  logic [FRAME_BITS-1:0]   power_up_frame;
  logic [FRAME_BITS-1:0]   load_frame;

  // tf = (f - floor) / 2, sent as (tf / 32) << 7 plus tf % 32
  always_comb begin
    if (frequency_mhz < FREQ_FLOOR) begin
      freq_offset = '0;
    end else begin
      freq_offset = frequency_mhz - FREQ_FLOOR;
    end
    freq_word = {5'd0, freq_offset[13:6], 2'd0, freq_offset[5:1]};
  end

  always_comb begin
    op_known    = 1'b1;
    cmd_address = ADDRESS_BITS'(REG_POWER);
    cmd_data    = DATA_BITS'(POWER_UP_WORD);
    unique case (op)
      OP_SET_FREQ: begin
        cmd_address = ADDRESS_BITS'(REG_SYNTH_B);
        cmd_data    = DATA_BITS'(freq_word);
      end
      OP_POWER_UP: begin
        cmd_address = ADDRESS_BITS'(REG_POWER);
        cmd_data    = DATA_BITS'(POWER_UP_WORD);
      end
      OP_POWER_DOWN: begin
        cmd_address = ADDRESS_BITS'(REG_POWER);
        cmd_data    = DATA_BITS'(POWER_DOWN_WORD);
      end
      OP_WAKE: begin
        cmd_address = ADDRESS_BITS'(REG_STATE);
        cmd_data    = '0;
      end
      OP_RAW_WRITE: begin
        cmd_address = raw_address;
        cmd_data    = raw_data;
      end
      default: begin
        op_known = 1'b0;
      end
    endcase
  end

  assign cmd_frame      = {cmd_data, 1'b1, cmd_address};
  assign power_up_frame = {DATA_BITS'(POWER_UP_WORD), 1'b1, ADDRESS_BITS'(REG_POWER)};
  assign load_frame     = (state == S_IDLE) ? cmd_frame : power_up_frame;

  always_comb begin
    state_next       = state;
    tmr_ctrl.start   = 1'b0;
    tmr_ctrl.us      = setup_time_us;
    shf_ctrl.load    = 1'b0;
    shf_ctrl.advance = 1'b0;
    load_second      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && op_known) begin
          shf_ctrl.load  = 1'b1;
          tmr_ctrl.start = 1'b1;
          tmr_ctrl.us    = frame_gap_us;
          state_next     = S_GAP;
        end
      end
      S_GAP: begin
        if (tmr_done) begin
          tmr_ctrl.start = 1'b1;
          tmr_ctrl.us    = setup_time_us;
          state_next     = S_SETUP;
        end
      end
      S_SETUP: begin
        if (tmr_done) begin
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        if (out_ready) begin
          shf_ctrl.advance = 1'b1;
          tmr_ctrl.start   = 1'b1;
          tmr_ctrl.us      = clock_high_us;
          state_next       = S_HIGH;
        end
      end
      S_HIGH: begin
        if (tmr_done) begin
          tmr_ctrl.start = 1'b1;
          tmr_ctrl.us    = hold_time_us;
          state_next     = S_HOLD;
        end
      end
      S_HOLD: begin
        if (tmr_done) begin
          if (!shf_status.at_start) begin
            tmr_ctrl.start = 1'b1;
            tmr_ctrl.us    = setup_time_us;
            state_next     = S_SETUP;
          end else if (second_frame_pending) begin
            // wake: follow with the power-up frame
            shf_ctrl.load  = 1'b1;
            load_second    = 1'b1;
            tmr_ctrl.start = 1'b1;
            tmr_ctrl.us    = frame_gap_us;
            state_next     = S_GAP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      second_frame_pending  <= 1'b0;
      power_down_flag       <= 1'b0;
      ticks_per_microsecond <= 16'd50;
      setup_time_us         <= 8'd2;
      clock_high_us         <= 8'd5;
      hold_time_us          <= 8'd2;
      frame_gap_us          <= 8'd5;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        case (op) inside
          OP_POWER_UP: power_down_flag <= 1'b0;
          OP_POWER_DOWN: power_down_flag <= 1'b1;
          OP_WAKE: begin
            power_down_flag      <= 1'b0;
            second_frame_pending <= 1'b1;
          end
          default: ;
        endcase
      end
      if (load_second) begin
        second_frame_pending <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TICKS_PER_US: ticks_per_microsecond <= cfg_data;
          CFG_SETUP_US:     setup_time_us         <= cfg_data[US_BITS-1:0];
          CFG_CLOCK_HIGH:   clock_high_us         <= cfg_data[US_BITS-1:0];
          CFG_HOLD_US:      hold_time_us          <= cfg_data[US_BITS-1:0];
          CFG_FRAME_GAP:    frame_gap_us          <= cfg_data[US_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  rxsfw_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .ticks_per_us (ticks_per_microsecond),
    .ctrl         (tmr_ctrl),
    .done         (tmr_done)
  );

  rxsfw_shifter #(
    .FRAME_BITS (FRAME_BITS)
  ) u_shifter (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (shf_ctrl),
    .load_frame (load_frame),
    .status     (shf_status)
  );

  assign in_ready     = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = (state == S_SEND);
  assign serial_bit   = shf_status.lsb;
  assign frame_end    = shf_status.last_bit;
  assign last         = shf_status.last_bit && !second_frame_pending;
  assign powered_down = power_down_flag;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the receiver synthesizer serial frame writer.
`timescale 1ns / 1ps
module tb_top;
  import rxsfw_pkg::*;

  localparam int ADDR_W  = ADDRESS_BITS_DEFAULT;
  localparam int DATA_W  = DATA_BITS_DEFAULT;
  localparam int FRAME_W = ADDR_W + 1 + DATA_W;

  localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_C = 3'd7;

  localparam int LONG_HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [FREQ_BITS-1:0] freq;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    data;
  } command_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_end;
    logic last;
    logic powered_down;
  } line_bit_t;

  typedef struct packed {
    command_t           cmd;
    logic               typed;
    logic               typed_none;
    logic [FRAME_W-1:0] typed_frame;
    logic               typed_pd;
  } table_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [OP_BITS-1:0]        op;
  logic [FREQ_BITS-1:0]      frequency_mhz;
  logic [ADDR_W-1:0]         raw_address;
  logic [DATA_W-1:0]         raw_data;
  logic                      out_valid;
  logic                      out_ready;
  logic                      serial_bit;
  logic                      frame_end;
  logic                      last;
  logic                      powered_down;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  line_bit_t  expected_bits[$];
  table_row_t stim_table[$];
  logic       pd_model;
  bit         busy_since_drain;
  int         timing_regs[0:4];
  int         mismatch_count;
  int         bit_count;
  int         sender_idle_pct;
  int         receiver_stall_pct;
  int         hold_len;
  bit         hold_taken;
  int         hold_left;
  line_bit_t  got_bit;
  line_bit_t  want_bit;
  string      field_names[4];

  rx_synth_serial_frame_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .frequency_mhz (frequency_mhz),
    .raw_address   (raw_address),
    .raw_data      (raw_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .serial_bit    (serial_bit),
    .frame_end     (frame_end),
    .last          (last),
    .powered_down  (powered_down),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [FRAME_W-1:0] frame_word(input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] data);
    return {data, 1'b1, addr};
  endfunction

  function automatic int drain_cycles();
    return timing_regs[CFG_TICKS_PER_US] * (timing_regs[CFG_CLOCK_HIGH] +
           timing_regs[CFG_HOLD_US] + timing_regs[CFG_FRAME_GAP]) + 16;
  endfunction

  task automatic push_frame(input logic [FRAME_W-1:0] word, input logic pd,
                            input bit closes_command);
    line_bit_t rec;
    for (int i = 0; i < FRAME_W; i++) begin
      rec.serial_bit   = word[i];
      rec.frame_end    = (i == FRAME_W - 1);
      rec.last         = closes_command && (i == FRAME_W - 1);
      rec.powered_down = pd;
      expected_bits.push_back(rec);
    end
  endtask

  // Work out the line bits of one command; with emit clear only update the power-down model and drain flag.
  task automatic serialize_command(input command_t c, input bit emit);
    logic [FRAME_W-1:0] first_word;
    logic [FRAME_W-1:0] second_word;
    int                 frames;
    int                 f;
    int                 tf;
    frames      = 1;
    first_word  = '0;
    second_word = '0;
    case (c.op)
      OP_SET_FREQ: begin
        f = int'(c.freq);
        if (f < int'(FREQ_FLOOR)) f = int'(FREQ_FLOOR);
        tf = (f - int'(FREQ_FLOOR)) / 2;
        first_word = frame_word(REG_SYNTH_B[ADDR_W-1:0],
                                DATA_W'(((tf / 32) << 7) + (tf % 32)));
      end
      OP_POWER_UP: begin
        first_word = frame_word(REG_POWER[ADDR_W-1:0], POWER_UP_WORD);
        pd_model = 1'b0;
      end
      OP_POWER_DOWN: begin
        first_word = frame_word(REG_POWER[ADDR_W-1:0], POWER_DOWN_WORD);
        pd_model = 1'b1;
      end
      OP_WAKE: begin
        first_word  = frame_word(REG_STATE[ADDR_W-1:0], '0);
        second_word = frame_word(REG_POWER[ADDR_W-1:0], POWER_UP_WORD);
        frames   = 2;
        pd_model = 1'b0;
      end
      OP_RAW_WRITE: begin
        first_word = frame_word(c.addr, c.data);
      end
      default: begin
        frames = 0;
      end
    endcase
    if (frames > 0) busy_since_drain = 1'b1;
    if (emit && frames > 0) begin
      push_frame(first_word, pd_model, frames == 1);
      if (frames == 2) push_frame(second_word, pd_model, 1'b1);
    end
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_BITS-1:0] index, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timing_regs[index] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input int ticks, input int setup, input int high,
                            input int hold, input int gap);
    write_cfg(CFG_TICKS_PER_US, ticks);
    write_cfg(CFG_SETUP_US, setup);
    write_cfg(CFG_CLOCK_HIGH, high);
    write_cfg(CFG_HOLD_US, hold);
    write_cfg(CFG_FRAME_GAP, gap);
  endtask

  task automatic send_command(input command_t c);
    @(negedge clk);
    in_valid      <= 1'b1;
    op            <= c.op;
    frequency_mhz <= c.freq;
    raw_address   <= c.addr;
    raw_data      <= c.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic sender_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Wait for every expected bit, then let the trailing clock phases run out.
  task automatic settle_block();
    while (expected_bits.size() != 0) @(posedge clk);
    if (busy_since_drain) repeat (drain_cycles()) @(posedge clk);
    busy_since_drain = 1'b0;
  endtask

  function automatic command_t random_command();
    command_t c;
    int       sel;
    if ($urandom_range(99) < 90) c.op = OP_BITS'($urandom_range(OP_RAW_WRITE, OP_SET_FREQ));
    else c.op = OP_BITS'($urandom_range(OP_SPARE_C, OP_SPARE_A));
    sel = $urandom_range(3);
    case (sel)
      0:       c.freq = FREQ_BITS'($urandom_range(FREQ_FLOOR - 1, 0));
      1:       c.freq = FREQ_BITS'($urandom_range(FREQ_FLOOR + 11, FREQ_FLOOR - 9));
      default: c.freq = FREQ_BITS'($urandom_range((1 << FREQ_BITS) - 1, 0));
    endcase
    c.addr = ADDR_W'($urandom);
    c.data = DATA_W'($urandom);
    return c;
  endfunction

  task automatic run_random_phase(input int count, input int tx_pct, input int rx_pct,
                                  input bit long_hold);
    command_t c;
    int       n;
    n = 0;
    sender_idle_pct    = tx_pct;
    receiver_stall_pct = rx_pct;
    if (long_hold) hold_len = LONG_HOLD_CYCLES;
    while (n < count) begin
      c = random_command();
      send_command(c);
      serialize_command(c, 1'b1);
      if (c.op <= OP_RAW_WRITE) n++;
      // pause the sender until every expected bit has been taken
      if ((long_hold && n == count / 2) || $urandom_range(99) < 5) begin
        release_input();
        while (expected_bits.size() != 0) @(posedge clk);
      end
      sender_gap();
    end
    release_input();
    settle_block();
  endtask

  task automatic add_row(input logic [OP_BITS-1:0] o, input int f, input int a, input int d,
                         input bit typed, input bit none, input logic [FRAME_W-1:0] word,
                         input logic pd);
    table_row_t r;
    r.cmd.op      = o;
    r.cmd.freq    = FREQ_BITS'(f);
    r.cmd.addr    = ADDR_W'(a);
    r.cmd.data    = DATA_W'(d);
    r.typed       = typed;
    r.typed_none  = none;
    r.typed_frame = word;
    r.typed_pd    = pd;
    stim_table.push_back(r);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_taken && hold_len != 0) begin
        hold_taken = 1'b1;
        hold_left  = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_bit = '{serial_bit, frame_end, last, powered_down};
      if (expected_bits.size() == 0) begin
        mismatch_count++;
        $display("%0t: bit transfer %0d with nothing expected, got %b", $time, bit_count,
                 got_bit);
      end else begin
        want_bit = expected_bits.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got_bit[i] !== want_bit[i]) begin
            mismatch_count++;
            $display("%0t: bit transfer %0d %s expected %b got %b", $time, bit_count,
                     field_names[i], want_bit[i], got_bit[i]);
          end
        end
      end
      bit_count++;
    end
  end

  initial begin
    table_row_t row;
    field_names        = '{"powered_down", "last", "frame_end", "serial_bit"};
    timing_regs        = '{50, 2, 5, 2, 5};
    pd_model           = 1'b0;
    busy_since_drain   = 1'b0;
    mismatch_count     = 0;
    bit_count          = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_len           = 0;
    hold_taken         = 1'b0;
    hold_left          = 0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    op            <= OP_SET_FREQ;
    frequency_mhz <= '0;
    raw_address   <= '0;
    raw_data      <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_TICKS_PER_US;
    cfg_data      <= '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset timing: two random commands at full-length line timing
    run_random_phase(2, 0, 0, 1'b0);

    // fastest line timing for the directed table
    set_timing(1, 1, 1, 1, 1);
    add_row(OP_POWER_DOWN, 0, 0, 0, 1, 0, 25'h1FFFFFA, 1'b1);
    add_row(OP_SET_FREQ, 0, 0, 0, 1, 0, 25'h0000011, 1'b1);
    add_row(OP_SET_FREQ, 478, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_SET_FREQ, 479, 0, 0, 1, 0, 25'h0000011, 1'b1);
    add_row(OP_SET_FREQ, 480, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_SET_FREQ, 481, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_SET_FREQ, 16383, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_WAKE, 0, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_POWER_UP, 0, 0, 0, 1, 0, 25'h1A1BE7A, 1'b0);
    add_row(OP_RAW_WRITE, 0, 0, 0, 1, 0, 25'h0000010, 1'b0);
    add_row(OP_RAW_WRITE, 0, REG_STATE, 20'hFFFFF, 1, 0, 25'h1FFFFFF, 1'b0);
    add_row(OP_POWER_DOWN, 0, 0, 0, 1, 0, 25'h1FFFFFA, 1'b1);
    add_row(OP_RAW_WRITE, 0, REG_POWER, 0, 0, 0, '0, 1'b0);
    add_row(OP_RAW_WRITE, 0, REG_POWER, POWER_UP_WORD, 0, 0, '0, 1'b0);
    add_row(OP_SPARE_A, 16383, REG_STATE, 20'hFFFFF, 1, 1, '0, 1'b0);
    add_row(OP_SPARE_B, 0, 0, 0, 1, 1, '0, 1'b0);
    add_row(OP_SPARE_C, 8191, 5, 20'h12345, 1, 1, '0, 1'b0);
    add_row(OP_WAKE, 0, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_RAW_WRITE, 0, 5, 20'hAAAAA, 0, 0, '0, 1'b0);
    add_row(OP_RAW_WRITE, 0, REG_POWER, 20'h55555, 0, 0, '0, 1'b0);
    add_row(OP_SET_FREQ, 14'h2AAA, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_SET_FREQ, 14'h1555, 0, 0, 0, 0, '0, 1'b0);
    add_row(OP_POWER_UP, 0, 0, 0, 0, 0, '0, 1'b0);
    foreach (stim_table[i]) begin
      row = stim_table[i];
      send_command(row.cmd);
      serialize_command(row.cmd, !row.typed);
      if (row.typed && !row.typed_none) push_frame(row.typed_frame, row.typed_pd, 1'b1);
    end
    release_input();
    settle_block();

    // slowest phases at one tick per microsecond
    set_timing(1, 255, 255, 255, 255);
    run_random_phase(2, 0, 0, 1'b0);

    // widest prescale: only a command that sends nothing
    set_timing(1, 1, 1, 1, 1);
    write_cfg(CFG_TICKS_PER_US, 16'hFFFF);
    row.cmd = random_command();
    row.cmd.op = OP_SPARE_B;
    send_command(row.cmd);
    serialize_command(row.cmd, 1'b1);
    release_input();
    settle_block();

    set_timing($urandom_range(2, 1), $urandom_range(3, 1), $urandom_range(3, 1),
               $urandom_range(3, 1), $urandom_range(3, 1));
    run_random_phase(18, 0, 0, 1'b1);
    set_timing($urandom_range(2, 1), $urandom_range(3, 1), $urandom_range(3, 1),
               $urandom_range(3, 1), $urandom_range(3, 1));
    run_random_phase(18, 50, 0, 1'b0);
    set_timing($urandom_range(2, 1), $urandom_range(3, 1), $urandom_range(3, 1),
               $urandom_range(3, 1), $urandom_range(3, 1));
    run_random_phase(18, 0, 50, 1'b0);
    set_timing($urandom_range(2, 1), $urandom_range(3, 1), $urandom_range(3, 1),
               $urandom_range(3, 1), $urandom_range(3, 1));
    run_random_phase(18, 31, 31, 1'b0);

    busy_since_drain = 1'b1;
    settle_block();
    if (mismatch_count == 0 && expected_bits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rxsfw_pkg.sv
design/rxsfw_timer.sv
design/rxsfw_shifter.sv
design/rx_synth_serial_frame_writer.sv
tb/tb_top.sv
